/* rtl/imuavg_pkg.sv */
// ----------------------------------------------------------------------------
// imuavg_pkg
// Shared constants and register codes for the IMU accelerometer averager.
// ----------------------------------------------------------------------------
package imuavg_pkg;

    // Axis slots inside a packed sample triple, lowest first
    localparam int NUM_AXES = 3;
    localparam int AX_X     = 0;
    localparam int AX_Y     = 1;
    localparam int AX_Z     = 2;

    // Configuration port
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam int REG_IDX_W = 1;

    // Vertical offset register, 1/4096 g per LSB
    localparam int                   OFFSET_W     = 16;
    localparam logic [OFFSET_W-1:0]  OFFSET_RESET = 16'sd4096;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_VERT_OFFSET = 1'b0
    } t_reg_idx;

endpackage

/* rtl/imuavg_ram.sv */
// ----------------------------------------------------------------------------
// imuavg_ram
// Generic simple dual-port RAM, one write and one registered read port.
// A read and a write to the same address in one cycle return the old data.
// ----------------------------------------------------------------------------
module imuavg_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 10
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/imu_accel_moving_average.sv */
// ----------------------------------------------------------------------------
// imu_accel_moving_average
// Boxcar moving average of three accelerometer axes with axis remap and a
// programmable vertical offset; gyro axes pass through with y and z swapped.
// A word passes stage registers s1 to s5 and the output register. Throughput:
// one word per cycle while the master side does not stall, set by the
// read-modify-write of the sample ring RAM and the running-sum registers.
// Reset (synchronous, active low): ring reads as zero until first filled,
// sums and ring pointer clear, vertical offset returns to 4096 (1 g).
// ----------------------------------------------------------------------------
module imu_accel_moving_average
    import imuavg_pkg::*;
#(
    parameter int WINDOW      = 10,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // Sample stream in
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // accel_x_sample, accel_y_sample, accel_z_sample,
    // gyro_x_sample, gyro_y_sample, gyro_z_sample (lowest bits first)
    input  logic [((6*SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,
    // Result stream out
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // avg_x, avg_y, avg_z, rate_x, rate_y, rate_z (lowest bits first)
    output logic [((6*SAMPLE_BITS+7)/8)*8-1:0]       m_axis_tdata,
    // Configuration port
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [PADDR_W-1:0]                       paddr,
    input  logic [PDATA_W-1:0]                       pwdata,
    output logic [PDATA_W-1:0]                       prdata,
    output logic                                     pready
);

    // ------------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------------
    localparam int S       = SAMPLE_BITS;
    localparam int DATA_W  = ((6*SAMPLE_BITS+7)/8)*8;
    localparam int POS_W   = $clog2(WINDOW);
    // A full window sum of signed samples fits S + log2(WINDOW) bits
    localparam int SUM_W   = S + $clog2(WINDOW);
    localparam int MAG_W   = SUM_W;
    // Reciprocal scaling: floor(m * RECIP / 2^K) == floor(m / WINDOW)
    // for every magnitude m below 2^MAG_W
    localparam int K       = MAG_W + $clog2(WINDOW);
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << K) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam logic [MAG_W:0] RECIP = RECIP_FULL[MAG_W:0];
    localparam int PROD_W  = 2*MAG_W + 1;
    localparam int ADD_W   = ((S > OFFSET_W) ? S : OFFSET_W) + 1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW - 1);

    // ------------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------------
    logic [OFFSET_W-1:0] r_voff;
    logic                w_cfg_wr;
    t_reg_idx            w_cfg_idx;

    assign pready    = 1'b1;
    assign w_cfg_idx = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        case (w_cfg_idx)
            REG_VERT_OFFSET: prdata = {{(PDATA_W-OFFSET_W){r_voff[OFFSET_W-1]}}, r_voff};
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Stage handshake: each stage advances when the one ahead frees up,
    // so bubbles close up and the input keeps flowing while a result waits.
    // ------------------------------------------------------------------------
    logic r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_s5_v, r_out_v;
    logic w_en1, w_en2, w_en3, w_en4, w_en5, w_en_out;
    logic w_acc;

    assign w_en_out      = !r_out_v || m_axis_tready;
    assign w_en5         = !r_s5_v  || w_en_out;
    assign w_en4         = !r_s4_v  || w_en5;
    assign w_en3         = !r_s3_v  || w_en4;
    assign w_en2         = !r_s2_v  || w_en3;
    assign w_en1         = !r_s1_v  || w_en2;
    assign s_axis_tready = w_en1;
    assign w_acc         = s_axis_tvalid && w_en1;

    // ------------------------------------------------------------------------
    // Accept: write the new triple into the ring slot and read back the
    // triple it replaces in the same cycle (RAM returns the old contents).
    // ------------------------------------------------------------------------
    logic [POS_W-1:0]          r_pos;
    logic                      r_full;   // ring has wrapped once; old data is real
    logic [NUM_AXES*S-1:0]     w_ram_rd;
    logic [3*S-1:0]            w_in_rate;

    imuavg_ram #(
        .WIDTH (NUM_AXES*S),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (w_acc),
        .i_wr_addr (r_pos),
        .i_wr_data (s_axis_tdata[NUM_AXES*S-1:0]),
        .i_rd_en   (w_acc),
        .i_rd_addr (r_pos),
        .o_rd_data (w_ram_rd)
    );

    // Remap gyro: x, then z as y, then y as z
    assign w_in_rate = {s_axis_tdata[4*S +: S], s_axis_tdata[5*S +: S],
                        s_axis_tdata[3*S +: S]};

    // ------------------------------------------------------------------------
    // Pipeline payload
    // ------------------------------------------------------------------------
    logic [S-1:0]        r_s1_acc  [NUM_AXES];
    logic                r_s1_full;
    logic [3*S-1:0]      r_s1_rate;

    logic [SUM_W-1:0]    r_sum     [NUM_AXES];   // running window sums
    logic [SUM_W-1:0]    n_sum     [NUM_AXES];
    logic [SUM_W-1:0]    r_s2_sum  [NUM_AXES];
    logic [3*S-1:0]      r_s2_rate;

    logic [MAG_W-1:0]    r_s3_mag  [NUM_AXES];
    logic                r_s3_neg  [NUM_AXES];
    logic [3*S-1:0]      r_s3_rate;

    logic [PROD_W-1:0]   r_s4_prod [NUM_AXES];
    logic                r_s4_neg  [NUM_AXES];
    logic [3*S-1:0]      r_s4_rate;

    logic [S-1:0]        w_quo     [NUM_AXES];
    logic [S-1:0]        r_s5_q    [NUM_AXES];
    logic [3*S-1:0]      r_s5_rate;

    logic [ADD_W-1:0]    w_vsum;
    logic [ADD_W-S:0]    w_vtop;
    logic [S-1:0]        w_vsat;
    logic [6*S-1:0]      r_out_fields;

    // Running sum update: drop the replaced sample, add the new one.
    // Before the first wrap the replaced slot is not subtracted (r_s1_full clear).
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            n_sum[a] = r_sum[a]
                + {{(SUM_W-S){r_s1_acc[a][S-1]}}, r_s1_acc[a]}
                - (r_s1_full ? {{(SUM_W-S){w_ram_rd[a*S+S-1]}}, w_ram_rd[a*S +: S]}
                             : SUM_W'(0));
        end
    end

    // Scale the magnitude back down and restore the sign (truncate toward zero)
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            w_quo[a] = r_s4_neg[a] ? (S'(0) - r_s4_prod[a][K +: S]) : r_s4_prod[a][K +: S];
        end
    end

    // Vertical channel: sensor y average plus offset, clamp to sample range
    always_comb begin
        w_vsum = {{(ADD_W-S){r_s5_q[AX_Y][S-1]}}, r_s5_q[AX_Y]}
               + {{(ADD_W-OFFSET_W){r_voff[OFFSET_W-1]}}, r_voff};
        w_vtop = w_vsum[ADD_W-1:S-1];
        if ((&w_vtop) || !(|w_vtop)) begin
            w_vsat = w_vsum[S-1:0];
        end else if (w_vsum[ADD_W-1]) begin
            w_vsat = {1'b1, {(S-1){1'b0}}};
        end else begin
            w_vsat = {1'b0, {(S-1){1'b1}}};
        end
    end

    // ------------------------------------------------------------------------
    // Control and state registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voff  <= OFFSET_RESET;
            r_pos   <= '0;
            r_full  <= 1'b0;
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_s4_v  <= 1'b0;
            r_s5_v  <= 1'b0;
            r_out_v <= 1'b0;
            for (int a = 0; a < NUM_AXES; a++) begin
                r_sum[a] <= '0;
            end
        end else begin
            if (w_cfg_wr && (w_cfg_idx == REG_VERT_OFFSET)) begin
                r_voff <= pwdata[OFFSET_W-1:0];
            end
            // Advance the ring pointer; mark the ring filled on the first wrap
            if (w_acc) begin
                if (r_pos == POS_LAST) begin
                    r_pos  <= '0;
                    r_full <= 1'b1;
                end else begin
                    r_pos <= r_pos + POS_W'(1);
                end
            end
            if (w_en1)    r_s1_v  <= s_axis_tvalid;
            if (w_en2)    r_s2_v  <= r_s1_v;
            if (w_en3)    r_s3_v  <= r_s2_v;
            if (w_en4)    r_s4_v  <= r_s3_v;
            if (w_en5)    r_s5_v  <= r_s4_v;
            if (w_en_out) r_out_v <= r_s5_v;
            // Commit the sum once, as the word leaves the update stage
            if (w_en2 && r_s1_v) begin
                for (int a = 0; a < NUM_AXES; a++) begin
                    r_sum[a] <= n_sum[a];
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_s1_acc[a] <= s_axis_tdata[a*S +: S];
            end
            r_s1_full <= r_full;
            r_s1_rate <= w_in_rate;
        end
        if (w_en2 && r_s1_v) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_s2_sum[a] <= n_sum[a];
            end
            r_s2_rate <= r_s1_rate;
        end
        if (w_en3 && r_s2_v) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_s3_neg[a] <= r_s2_sum[a][SUM_W-1];
                r_s3_mag[a] <= r_s2_sum[a][SUM_W-1] ? (MAG_W'(0) - r_s2_sum[a]) : r_s2_sum[a];
            end
            r_s3_rate <= r_s2_rate;
        end
        if (w_en4 && r_s3_v) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_s4_prod[a] <= r_s3_mag[a] * RECIP;
                r_s4_neg[a]  <= r_s3_neg[a];
            end
            r_s4_rate <= r_s3_rate;
        end
        if (w_en5 && r_s4_v) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_s5_q[a] <= w_quo[a];
            end
            r_s5_rate <= r_s4_rate;
        end
        // Output: x average, sensor z as y, offset sensor y as z, then rates
        if (w_en_out && r_s5_v) begin
            r_out_fields <= {r_s5_rate, w_vsat, r_s5_q[AX_Z], r_s5_q[AX_X]};
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = DATA_W'(r_out_fields);

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // Wrapping the pointer always leaves the ring marked as filled
    a_pos_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (r_pos == POS_LAST)) |=> ((r_pos == '0) && r_full))
        else $error("ring pointer wrap did not mark the ring filled");

    // Input back-pressure only when every stage is occupied and output stalls
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_s1_v && r_s2_v && r_s3_v && r_s4_v && r_s5_v
                            && r_out_v && !m_axis_tready))
        else $error("input stalled with a free pipeline stage");

    // Filled flag never drops outside reset
    a_full_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |=> r_full)
        else $error("ring filled flag cleared without reset");

endmodule

/* tb/imuavg_tb_pkg.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// imuavg_tb_pkg
// Word formats and the result scoreboard for the IMU accelerometer averager:
// tracks the sample window and vertical offset, predicts each result word.
// ----------------------------------------------------------------------------
package imuavg_tb_pkg;
    import imuavg_pkg::*;

    localparam int AVG_WINDOW  = 10;
    localparam int SAMPLE_W    = 16;
    localparam int SUM_W       = 20;
    localparam int WORD_W      = ((6*SAMPLE_W+7)/8)*8;
    localparam int SAMPLE_MAX  = 32767;
    localparam int SAMPLE_MIN  = -32768;
    localparam int REG_STRIDE  = 4;

    localparam logic [PADDR_W-1:0] OFFSET_ADDR =
        PADDR_W'(int'(REG_VERT_OFFSET) * REG_STRIDE);
    localparam logic [PADDR_W-1:0] SPARE_ADDR =
        PADDR_W'((int'(REG_VERT_OFFSET) + 1) * REG_STRIDE);

    // Lowest field last so that ax sits in the lowest bits
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] gz;
        logic signed [SAMPLE_W-1:0] gy;
        logic signed [SAMPLE_W-1:0] gx;
        logic signed [SAMPLE_W-1:0] az;
        logic signed [SAMPLE_W-1:0] ay;
        logic signed [SAMPLE_W-1:0] ax;
    } t_imu_sample;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] rate_z;
        logic signed [SAMPLE_W-1:0] rate_y;
        logic signed [SAMPLE_W-1:0] rate_x;
        logic signed [SAMPLE_W-1:0] avg_z;
        logic signed [SAMPLE_W-1:0] avg_y;
        logic signed [SAMPLE_W-1:0] avg_x;
    } t_imu_result;

    class accel_window_scoreboard;
        logic signed [SAMPLE_W-1:0] hist_x[AVG_WINDOW];
        logic signed [SAMPLE_W-1:0] hist_y[AVG_WINDOW];
        logic signed [SAMPLE_W-1:0] hist_z[AVG_WINDOW];
        logic signed [SUM_W-1:0]    total_x;
        logic signed [SUM_W-1:0]    total_y;
        logic signed [SUM_W-1:0]    total_z;
        int                         slot;
        logic signed [OFFSET_W-1:0] vert_offset;
        t_imu_result                awaited_q[$];
        string                      field_name[6];
        int                         errors;
        int                         samples_seen;
        int                         results_checked;

        function new();
            for (int i = 0; i < AVG_WINDOW; i++) begin
                hist_x[i] = '0;
                hist_y[i] = '0;
                hist_z[i] = '0;
            end
            total_x         = '0;
            total_y         = '0;
            total_z         = '0;
            slot            = 0;
            vert_offset     = OFFSET_RESET;
            field_name      = '{"avg_x", "avg_y", "avg_z", "rate_x", "rate_y", "rate_z"};
            errors          = 0;
            samples_seen    = 0;
            results_checked = 0;
        endfunction

        task report_mismatch(input string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        function void write_reg(input logic [PADDR_W-1:0] addr,
                                input logic [PDATA_W-1:0] data);
            // Only the offset register exists; everything above bit 15 is dropped
            if (addr == OFFSET_ADDR)
                vert_offset = data[OFFSET_W-1:0];
        endfunction

        task check_readback(input logic [PDATA_W-1:0] data);
            if (data[OFFSET_W-1:0] !== vert_offset)
                report_mismatch($sformatf("offset read back %0d, want %0d",
                    $signed(data[OFFSET_W-1:0]), vert_offset));
        endtask

        // Advance the window by one sample and queue the result it causes
        function void note_sample(input t_imu_sample s);
            t_imu_result r;
            int          sx;
            int          sy;
            int          sz;
            int          vert;
            total_x = total_x + s.ax - hist_x[slot];
            total_y = total_y + s.ay - hist_y[slot];
            total_z = total_z + s.az - hist_z[slot];
            hist_x[slot] = s.ax;
            hist_y[slot] = s.ay;
            hist_z[slot] = s.az;
            slot = (slot + 1 >= AVG_WINDOW) ? 0 : slot + 1;
            sx = total_x;
            sy = total_y;
            sz = total_z;
            // Integer division truncates toward zero, as the block must
            vert = sy / AVG_WINDOW + int'(vert_offset);
            if (vert > SAMPLE_MAX)
                vert = SAMPLE_MAX;
            else if (vert < SAMPLE_MIN)
                vert = SAMPLE_MIN;
            r.avg_x  = SAMPLE_W'(sx / AVG_WINDOW);
            r.avg_y  = SAMPLE_W'(sz / AVG_WINDOW);
            r.avg_z  = SAMPLE_W'(vert);
            r.rate_x = s.gx;
            r.rate_y = s.gz;
            r.rate_z = s.gy;
            awaited_q.push_back(r);
            samples_seen++;
        endfunction

        task check_result(input logic [WORD_W-1:0] word);
            logic [WORD_W-1:0] want;
            if (awaited_q.size() == 0) begin
                report_mismatch($sformatf("result word %0h with nothing outstanding", word));
                return;
            end
            want = awaited_q.pop_front();
            for (int f = 0; f < 6; f++) begin
                if (word[SAMPLE_W*f +: SAMPLE_W] !== want[SAMPLE_W*f +: SAMPLE_W])
                    report_mismatch($sformatf("result %0d field %s got %0d want %0d",
                        results_checked, field_name[f],
                        $signed(word[SAMPLE_W*f +: SAMPLE_W]),
                        $signed(want[SAMPLE_W*f +: SAMPLE_W])));
            end
            results_checked++;
        endtask

        function int outstanding();
            return awaited_q.size();
        endfunction

        task check_drained();
            if (awaited_q.size() != 0)
                report_mismatch($sformatf("%0d result words never arrived",
                    awaited_q.size()));
        endtask
    endclass

endpackage

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the IMU accelerometer averager: streams sample words
// with random gaps and back-pressure, reprograms the vertical offset between
// phases, and checks every result word against a running window prediction.
// ----------------------------------------------------------------------------
module testbench;
    import imuavg_pkg::*;
    import imuavg_tb_pkg::*;

    localparam int          RESULT_LATENCY = 5;
    localparam int unsigned CYCLE_LIMIT    = 400000;
    localparam int          PHASE_COUNT    = 7;
    localparam int          PHASE_ITEMS    = 125;

    // Accelerometer value shapes for the random part
    typedef enum int {
        SRC_SPREAD,
        SRC_HIGH,
        SRC_LOW,
        SRC_NEAR_ZERO
    } t_src_mode;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z (lowest bits first)
    logic [WORD_W-1:0]    s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // avg_x, avg_y, avg_z, rate_x, rate_y, rate_z (lowest bits first)
    logic [WORD_W-1:0]    m_axis_tdata;
    logic                 psel          = 1'b0;
    logic                 penable       = 1'b0;
    logic                 pwrite        = 1'b0;
    logic [PADDR_W-1:0]   paddr         = '0;
    logic [PDATA_W-1:0]   pwdata        = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    accel_window_scoreboard sb;
    bit                     idle_enable = 1'b1;
    int unsigned            cycle_count = 0;
    int                     offsets_set = 0;

    imu_accel_moving_average u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop: generous margin over the slowest legal run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    // Gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (!idle_enable || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] draw_value(input t_src_mode m);
        case (m)
            SRC_HIGH:      return SAMPLE_W'($urandom_range(SAMPLE_MAX, SAMPLE_MAX - 767));
            SRC_LOW:       return SAMPLE_W'(int'($urandom_range(0, 767)) + SAMPLE_MIN);
            SRC_NEAR_ZERO: return SAMPLE_W'(int'($urandom_range(0, 40)) - 20);
            default:       return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic t_imu_sample draw_sample(input t_src_mode m);
        t_imu_sample s;
        s.ax = draw_value(m);
        s.ay = draw_value(m);
        s.az = draw_value(m);
        // Gyro words only pass through, so spread them over the full range
        s.gx = SAMPLE_W'($urandom);
        s.gy = SAMPLE_W'($urandom);
        s.gz = SAMPLE_W'($urandom);
        return s;
    endfunction

    function automatic t_src_mode pick_mode();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 4)
            return SRC_SPREAD;
        if (roll < 6)
            return SRC_HIGH;
        if (roll < 8)
            return SRC_LOW;
        return SRC_NEAR_ZERO;
    endfunction

    // Collect result words; the sink decides back-pressure below
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // Sink: hold tready low for a random stall, then release it
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                stall--;
            end else begin
                m_axis_tready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    // Enter and leave at a falling edge; tvalid stays high across back-to-back words
    task automatic send_sample(input t_imu_sample s);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= s;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_sample(s);
        @(negedge i_clk);
    endtask

    // Write with junk in the upper half of pwdata; the register keeps 16 bits
    task automatic apb_write(input logic [PADDR_W-1:0] addr,
                             input logic [OFFSET_W-1:0] value);
        logic [PDATA_W-1:0] word;
        word = {(PDATA_W-OFFSET_W)'($urandom), value};
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= word;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(addr, word);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read_offset();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= OFFSET_ADDR;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.check_readback(prdata);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Drop tvalid, wait for every outstanding result, then let the pipe settle
    task automatic wait_for_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(negedge i_clk);
        repeat (RESULT_LATENCY + 4) @(negedge i_clk);
    endtask

    // Random words in runs of one shape; the first run is forced to lead_mode
    task automatic random_run(input t_src_mode lead_mode, input int count);
        t_src_mode mode;
        int        run_left;
        mode     = lead_mode;
        run_left = 12;
        for (int n = 0; n < count; n++) begin
            if (run_left == 0) begin
                mode     = pick_mode();
                run_left = $urandom_range(5, 30);
            end
            run_left--;
            send_sample(draw_sample(mode));
        end
    endtask

    // Directed words at the reset offset: full-scale positive window pushes the
    // vertical sum past the top, full-scale negative window walks sums through
    // negative truncation, a few tiny negatives finish it off
    task automatic directed_samples();
        t_imu_sample s;
        s = '{gz: '0, gy: SAMPLE_W'(SAMPLE_MIN), gx: SAMPLE_W'(SAMPLE_MAX),
              az: SAMPLE_W'(SAMPLE_MAX), ay: SAMPLE_W'(SAMPLE_MAX), ax: SAMPLE_W'(SAMPLE_MAX)};
        repeat (AVG_WINDOW + 1) send_sample(s);
        s = '{gz: '1, gy: SAMPLE_W'(SAMPLE_MAX), gx: SAMPLE_W'(SAMPLE_MIN),
              az: SAMPLE_W'(SAMPLE_MIN), ay: SAMPLE_W'(SAMPLE_MIN), ax: SAMPLE_W'(SAMPLE_MIN)};
        repeat (AVG_WINDOW + 1) send_sample(s);
        s = '{gz: 16'sd1, gy: -16'sd1, gx: '0, az: 16'sd1, ay: -16'sd3, ax: -16'sd1};
        repeat (3) send_sample(s);
    endtask

    initial begin
        t_src_mode                  lead;
        logic signed [OFFSET_W-1:0] offset_val;
        sb = new();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Phase 0 runs on the reset offset
        apb_read_offset();
        directed_samples();
        random_run(SRC_SPREAD, 60);
        wait_for_idle();

        for (int phase = 1; phase < PHASE_COUNT; phase++) begin
            case (phase)
                1: begin offset_val = 16'sh7fff;                 lead = SRC_NEAR_ZERO; end
                2: begin offset_val = 16'sh8000;                 lead = SRC_LOW;       end
                3: begin offset_val = '0;                        lead = SRC_SPREAD;    end
                5: begin offset_val = -16'sd1;                   lead = SRC_NEAR_ZERO; end
                4: begin offset_val = OFFSET_W'($urandom);       lead = SRC_HIGH;      end
                default: begin offset_val = OFFSET_W'($urandom); lead = SRC_LOW;       end
            endcase
            // Every third phase streams without any idling on either side
            idle_enable = (phase % 3 != 1);
            apb_write(SPARE_ADDR, OFFSET_W'($urandom));
            apb_write(OFFSET_ADDR, offset_val);
            apb_read_offset();
            offsets_set++;
            random_run(lead, PHASE_ITEMS);
            wait_for_idle();
        end

        sb.check_drained();
        $display("run covered %0d sample words and %0d result words", sb.samples_seen,
            sb.results_checked);
        $display("across %0d written offsets plus reset, with and without stalls",
            offsets_set);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/imuavg_pkg.sv
rtl/imuavg_ram.sv
rtl/imu_accel_moving_average.sv
tb/imuavg_tb_pkg.sv
tb/testbench.sv
